>>> design/rgb_to_hsv_pixel_defines.svh
// Assertion macros for the RGB to HSV pixel converter.
// No dependencies; included by the top level, which provides clk_i and rst_ni.
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// Checked only outside reset.
`define R2H_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define R2H_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/r2h_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies.
package r2h_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned OutW       = 7;
  localparam int unsigned QuotW      = 7;   // every quotient is below 128
  localparam int unsigned NumerW     = 11;  // hue numerator, below 6*255
  localparam int unsigned HueNumW    = 18;  // 100 * numerator
  localparam int unsigned HueDenW    = 11;  // 6 * delta
  localparam int unsigned SatNumW    = 15;  // 100 * delta
  localparam int unsigned SatDenW    = 8;   // max channel
  localparam int unsigned BrightW    = 16;  // 100 * max before /255
  localparam int unsigned ScalePct   = 100;
  localparam int unsigned HueSectors = 6;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [OutW-1:0] hue;
    logic [OutW-1:0] saturation;
    logic [OutW-1:0] brightness;
  } hsv_t;

  // After max/min search.
  typedef struct packed {
    logic [NumerW-1:0] numer;
    logic [ChanW-1:0]  delta;
    logic [ChanW-1:0]  maxv;
  } ext_t;

  // Dividends and divisors ready for the divider.
  typedef struct packed {
    logic [HueNumW-1:0] hue_num;
    logic [HueDenW-1:0] hue_den;
    logic [SatNumW-1:0] sat_num;
    logic [SatDenW-1:0] sat_den;
    logic [OutW-1:0]    brightness;
  } prep_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [HueNumW-1:0] hue_rem;
    logic [HueDenW-1:0] hue_den;
    logic [QuotW-1:0]   hue_q;
    logic [SatNumW-1:0] sat_rem;
    logic [SatDenW-1:0] sat_den;
    logic [QuotW-1:0]   sat_q;
    logic [OutW-1:0]    brightness;
  } div_t;

endpackage

>>> design/r2h_prep.sv
// Front end: max/min search and hue numerator, then scaling by 100 and brightness.
// Two register stages; depends on r2h_pkg.
module r2h_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  r2h_pkg::pixel_t in_pixel_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output r2h_pkg::prep_t  out_data_o
);
  import r2h_pkg::*;

  logic [ChanW-1:0]  r, g, b, mx, mn, d;
  logic [NumerW-1:0] r_w, g_w, b_w, d2, d4, d6;
  ext_t              ext_d, ext_q;
  logic              ext_valid_q;
  prep_t             prep_d, prep_q;
  logic              prep_valid_q;
  logic              ext_ready, prep_ready;
  logic [BrightW-1:0] bright_prod, bright_sum;

  assign r = in_pixel_i.red;
  assign g = in_pixel_i.green;
  assign b = in_pixel_i.blue;

  assign mx = (r >= g && r >= b) ? r : ((g >= b) ? g : b);
  assign mn = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
  assign d  = mx - mn;

  assign r_w = NumerW'(r);
  assign g_w = NumerW'(g);
  assign b_w = NumerW'(b);
  assign d2  = NumerW'(d) << 1;
  assign d4  = NumerW'(d) << 2;
  assign d6  = d2 + d4;

  // Sums wrap in NumerW bits; the true value always lies in [0, 6*delta), and is 0 for a zero delta.
  always_comb begin
    priority if (r >= g && r >= b) begin
      ext_d.numer = (g < b) ? (d6 + g_w - b_w) : (g_w - b_w);
    end else if (g >= b) begin
      ext_d.numer = d2 + b_w - r_w;
    end else begin
      ext_d.numer = d4 + r_w - g_w;
    end
    ext_d.delta = d;
    ext_d.maxv  = mx;
  end

  // x/255 == (x + (x >> 8) + 1) >> 8 for any 16-bit x below 65535
  assign bright_prod = BrightW'(ext_q.maxv) * BrightW'(ScalePct);
  assign bright_sum  = bright_prod + (bright_prod >> 8) + BrightW'(1);

  always_comb begin
    prep_d.hue_num = HueNumW'(ext_q.numer) * HueNumW'(ScalePct);
    // grey or black pixel: divisor 1 with zero dividend gives a zero quotient
    prep_d.hue_den = (ext_q.delta == '0) ? HueDenW'(1)
                                         : HueDenW'(ext_q.delta) * HueDenW'(HueSectors);
    prep_d.sat_num = SatNumW'(ext_q.delta) * SatNumW'(ScalePct);
    prep_d.sat_den = (ext_q.maxv == '0) ? SatDenW'(1) : SatDenW'(ext_q.maxv);
    prep_d.brightness = bright_sum[8 +: OutW];
  end

  assign prep_ready = !prep_valid_q || out_ready_i;
  assign ext_ready  = !ext_valid_q || prep_ready;
  assign in_ready_o = ext_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_valid_q  <= 1'b0;
      prep_valid_q <= 1'b0;
    end else begin
      if (ext_ready) begin
        ext_valid_q <= in_valid_i;
      end
      if (prep_ready) begin
        prep_valid_q <= ext_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ext_ready && in_valid_i) begin
      ext_q <= ext_d;
    end
    if (prep_ready && ext_valid_q) begin
      prep_q <= prep_d;
    end
  end

  assign out_valid_o = prep_valid_q;
  assign out_data_o  = prep_q;

endmodule

>>> design/r2h_div.sv
// Pipelined restoring divider: one quotient bit per stage for hue and saturation.
// QuotW register stages, the last one is the output register; depends on r2h_pkg.
module r2h_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  r2h_pkg::prep_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output r2h_pkg::hsv_t  out_hsv_o
);
  import r2h_pkg::*;

  localparam int unsigned NStage = QuotW;

  div_t             src [NStage];
  div_t             nxt [NStage];
  div_t             stage_q [NStage];
  logic [NStage-1:0] valid_q;
  logic [NStage-1:0] vin;
  logic [NStage:0]   rdy;

  always_comb begin
    src[0].hue_rem    = in_data_i.hue_num;
    src[0].hue_den    = in_data_i.hue_den;
    src[0].hue_q      = '0;
    src[0].sat_rem    = in_data_i.sat_num;
    src[0].sat_den    = in_data_i.sat_den;
    src[0].sat_q      = '0;
    src[0].brightness = in_data_i.brightness;
  end
  assign vin[0]      = in_valid_i;
  assign rdy[NStage] = out_ready_i;

  for (genvar k = 0; k < NStage; k++) begin : g_stage
    localparam int unsigned Sh = NStage - 1 - k;

    logic [HueNumW-1:0] hue_cmp;
    logic [SatNumW-1:0] sat_cmp;
    logic               hue_ge, sat_ge;

    if (k > 0) begin : g_link
      assign src[k] = stage_q[k-1];
      assign vin[k] = valid_q[k-1];
    end

    assign hue_cmp = HueNumW'(src[k].hue_den) << Sh;
    assign sat_cmp = SatNumW'(src[k].sat_den) << Sh;
    assign hue_ge  = src[k].hue_rem >= hue_cmp;
    assign sat_ge  = src[k].sat_rem >= sat_cmp;

    always_comb begin
      nxt[k]         = src[k];
      nxt[k].hue_rem = hue_ge ? (src[k].hue_rem - hue_cmp) : src[k].hue_rem;
      nxt[k].sat_rem = sat_ge ? (src[k].sat_rem - sat_cmp) : src[k].sat_rem;
      nxt[k].hue_q   = {src[k].hue_q[QuotW-2:0], hue_ge};
      nxt[k].sat_q   = {src[k].sat_q[QuotW-2:0], sat_ge};
    end

    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= vin[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vin[k]) begin
        stage_q[k] <= nxt[k];
      end
    end
  end

  assign in_ready_o            = rdy[0];
  assign out_valid_o           = valid_q[NStage-1];
  assign out_hsv_o.hue         = OutW'(stage_q[NStage-1].hue_q);
  assign out_hsv_o.saturation  = OutW'(stage_q[NStage-1].sat_q);
  assign out_hsv_o.brightness  = stage_q[NStage-1].brightness;

endmodule

>>> design/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter, hue scaled to 0..99, saturation and value scaled to 0..100.
// Register stages: 2 front-end stages plus one stage per quotient bit (7).
// Throughput one pixel per cycle when not stalled; every stage holds its transaction on stall.
// Reset (rst_ni, async, active low) clears all stage valid bits; no other state.
// Depends on r2h_pkg, r2h_prep, r2h_div and rgb_to_hsv_pixel_defines.svh.
`include "rgb_to_hsv_pixel_defines.svh"

module rgb_to_hsv_pixel (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  r2h_pkg::pixel_t in_pixel_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output r2h_pkg::hsv_t   out_hsv_o
);
  import r2h_pkg::*;

  prep_t prep_data;
  logic  prep_valid, prep_ready;

  r2h_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (prep_valid),
    .out_ready_i (prep_ready),
    .out_data_o  (prep_data)
  );

  r2h_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (prep_ready),
    .in_data_i   (prep_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_hsv_o   (out_hsv_o)
  );

  `R2H_ASSERT_RST(a_out_range, out_valid_o |-> (out_hsv_o.hue <= OutW'(99) && out_hsv_o.saturation <= OutW'(100) && out_hsv_o.brightness <= OutW'(100)), "result out of range")
  `R2H_ASSERT_RST(a_stall_only_when_full, !in_ready_o |-> (out_valid_o && !out_ready_i && prep_valid && !prep_ready), "input stalled with a free stage")
  `R2H_ASSERT_ALWAYS(a_reset_flush, !rst_ni |=> !out_valid_o, "result after reset")

endmodule
